@@ design/spi_ep_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ep_pkg: shared types and codes of the e-paper SPI slave
// Holds the bus preamble and command codes, the configuration register
// indexes and the structs that pass between the block's modules.
// ----------------------------------------------------------------------------
package spi_ep_pkg;

  // Width of the saturating pixel total.
  localparam int unsigned PixelCountWidth = 48;

  // Preamble words that open each bus word sequence.
  localparam logic [15:0] PreCmd = 16'h6000;
  localparam logic [15:0] PreWr  = 16'h0000;
  localparam logic [15:0] PreRd  = 16'h1000;

  // Controller commands.
  localparam logic [15:0] CmdRegRd   = 16'h0010;
  localparam logic [15:0] CmdRegWr   = 16'h0011;
  localparam logic [15:0] CmdLoad    = 16'h0021;
  localparam logic [15:0] CmdRefresh = 16'h0034;
  localparam logic [15:0] CmdVcom    = 16'h0039;
  localparam logic [15:0] CmdInfo    = 16'h0302;

  // Configuration register indexes.
  localparam logic [7:0] CfgEnabled     = 8'd0;
  localparam logic [7:0] CfgPanelWidth  = 8'd1;
  localparam logic [7:0] CfgPanelHeight = 8'd2;
  localparam logic [7:0] CfgPowerOnVcom = 8'd3;

  // Configuration reset values.
  localparam logic [15:0] PanelSizeReset  = 16'd128;
  localparam logic [15:0] PowerOnVcomReset = 16'd1530;

  // Pixels per word after a framing reset (8 bpp).
  localparam logic [3:0] PixelsPerWordReset = 4'd2;

  typedef struct packed {
    logic        enabled;
    logic [15:0] panel_width;
    logic [15:0] panel_height;
    logic [15:0] power_on_vcom;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 miso_byte;
    logic                       ready_level;
    logic [PixelCountWidth-1:0] pixels_loaded;
    logic [31:0]                refresh_count;
    logic [15:0]                last_waveform;
    logic [15:0]                vcom_millivolts;
  } result_t;

  // Pixel format code (bits 5:4 of the first load argument) to pixels per word.
  function automatic logic [3:0] format_pixels(input logic [1:0] code);
    logic [3:0] ppw;
    case (code)
      2'd0:    ppw = 4'd8;
      2'd1:    ppw = 4'd5;
      2'd2:    ppw = 4'd4;
      default: ppw = 4'd2;
    endcase
    return ppw;
  endfunction

endpackage : spi_ep_pkg
`default_nettype wire

@@ design/spi_ep_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ep_cfg: configuration register file
// Four software registers written over a valid/ready port; unknown
// indexes are accepted and dropped.
// ----------------------------------------------------------------------------
module spi_ep_cfg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i,
  output spi_ep_pkg::cfg_t      cfg_o
);
  import spi_ep_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_index_i)
        CfgEnabled:     cfg_d.enabled       = cfg_data_i[0];
        CfgPanelWidth:  cfg_d.panel_width   = cfg_data_i;
        CfgPanelHeight: cfg_d.panel_height  = cfg_data_i;
        CfgPowerOnVcom: cfg_d.power_on_vcom = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled       <= 1'b0;
      cfg_q.panel_width   <= PanelSizeReset;
      cfg_q.panel_height  <= PanelSizeReset;
      cfg_q.power_on_vcom <= PowerOnVcomReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : spi_ep_cfg
`default_nettype wire

@@ design/spi_ep_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ep_core: byte pairing, preamble decode and command tracking
// Holds the protocol state and updates it once per processed item; the
// result reflects the state after the update.
// ----------------------------------------------------------------------------
module spi_ep_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic            action_i,
  input  wire logic [7:0]      mosi_byte_i,
  input  wire spi_ep_pkg::cfg_t cfg_i,
  output spi_ep_pkg::result_t  result_o
);
  import spi_ep_pkg::*;

  localparam logic [1:0] PhasePre  = 2'd0;
  localparam logic [1:0] PhaseCmd  = 2'd1;
  localparam logic [1:0] PhaseData = 2'd2;

  // Argument index only matters up to five; it holds there.
  localparam logic [2:0] ArgIdxMax  = 3'd5;
  // Info word index only matters as zero, one or later.
  localparam logic [1:0] InfoIdxMax = 2'd2;

  logic [1:0]                 phase_q, phase_d;
  logic                       hbh_q, hbh_d;
  logic [7:0]                 hhb_q, hhb_d;
  logic [15:0]                cmd_q, cmd_d;
  logic [2:0]                 arg_q, arg_d;
  logic [1:0]                 info_q, info_d;
  logic [15:0]                vcom_q, vcom_d;
  logic                       vdir_one_q, vdir_one_d;
  logic [3:0]                 ppw_q, ppw_d;
  logic                       rd_act_q, rd_act_d;
  logic [2:0]                 rd_pos_q, rd_pos_d;
  logic [15:0]                rd_val_q, rd_val_d;
  logic [PixelCountWidth-1:0] pix_q, pix_d;
  logic [31:0]                refr_q, refr_d;
  logic [15:0]                wave_q, wave_d;

  logic [7:0]                 miso;
  logic [15:0]                word;
  logic [PixelCountWidth:0]   pix_sum;
  logic [1:0]                 rp;

  assign word    = {hhb_q, mosi_byte_i};
  assign pix_sum = {1'b0, pix_q} + {{(PixelCountWidth - 3){1'b0}}, ppw_q};
  assign rp      = rd_pos_q[1:0];

  always_comb begin
    phase_d    = phase_q;
    hbh_d      = hbh_q;
    hhb_d      = hhb_q;
    cmd_d      = cmd_q;
    arg_d      = arg_q;
    info_d     = info_q;
    vcom_d     = vcom_q;
    vdir_one_d = vdir_one_q;
    ppw_d      = ppw_q;
    rd_act_d   = rd_act_q;
    rd_pos_d   = rd_pos_q;
    rd_val_d   = rd_val_q;
    pix_d      = pix_q;
    refr_d     = refr_q;
    wave_d     = wave_q;
    miso       = 8'h00;

    if (fire_i && action_i) begin
      // Framing reset: keep totals and VCOM, restore VCOM if it was zero.
      phase_d    = PhasePre;
      hbh_d      = 1'b0;
      hhb_d      = 8'h00;
      cmd_d      = 16'h0000;
      arg_d      = 3'd0;
      info_d     = 2'd0;
      vdir_one_d = 1'b0;
      ppw_d      = PixelsPerWordReset;
      rd_act_d   = 1'b0;
      rd_pos_d   = 3'd0;
      rd_val_d   = 16'h0000;
      wave_d     = 16'h0000;
      if (vcom_q == 16'h0000) begin
        vcom_d = cfg_i.power_on_vcom;
      end
    end else if (fire_i && cfg_i.enabled) begin
      if (rd_act_q) begin
        // Burst: dummy word, then value word high byte first.
        if (rp == 2'd2) begin
          miso = rd_val_q[15:8];
        end else if (rp == 2'd3) begin
          miso = rd_val_q[7:0];
        end
        rd_pos_d = {1'b0, rp} + 3'd1;
        if (rp == 2'd3) begin
          rd_act_d = 1'b0;
          rd_pos_d = 3'd0;
        end
      end else if (!hbh_q) begin
        hhb_d = mosi_byte_i;
        hbh_d = 1'b1;
      end else begin
        hbh_d   = 1'b0;
        phase_d = PhasePre;
        unique case (phase_q)
          PhaseCmd: begin
            cmd_d = word;
            arg_d = 3'd0;
            if (word == CmdInfo) begin
              info_d = 2'd0;
            end
          end
          PhaseData: begin
            if (cmd_q == CmdVcom) begin
              if (arg_q == 3'd0) begin
                vdir_one_d = (word == 16'h0001);
              end else if (arg_q == 3'd1 && vdir_one_q) begin
                vcom_d = word;
              end
            end else if (cmd_q == CmdLoad) begin
              if (arg_q == 3'd0) begin
                ppw_d = format_pixels(word[5:4]);
              end else if (arg_q == ArgIdxMax) begin
                pix_d = pix_sum[PixelCountWidth] ? '1 : pix_sum[PixelCountWidth-1:0];
              end
            end else if (cmd_q == CmdRefresh) begin
              if (arg_q == 3'd4) begin
                wave_d = word;
                if (refr_q != '1) begin
                  refr_d = refr_q + 32'd1;
                end
              end
            end
            if (arg_q != ArgIdxMax) begin
              arg_d = arg_q + 3'd1;
            end
          end
          PhasePre: begin
            if (word == PreCmd) begin
              phase_d = PhaseCmd;
            end else if (word == PreWr) begin
              phase_d = PhaseData;
            end else if (word == PreRd) begin
              rd_val_d = 16'h0000;
              if (cmd_q == CmdVcom) begin
                rd_val_d = vcom_q;
              end else if (cmd_q == CmdInfo) begin
                if (info_q == 2'd0) begin
                  rd_val_d = cfg_i.panel_width;
                end else if (info_q == 2'd1) begin
                  rd_val_d = cfg_i.panel_height;
                end
                if (info_q != InfoIdxMax) begin
                  info_d = info_q + 2'd1;
                end
              end
              rd_pos_d = 3'd0;
              rd_act_d = 1'b1;
            end
          end
          default: phase_d = PhasePre;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhasePre;
      hbh_q      <= 1'b0;
      hhb_q      <= 8'h00;
      cmd_q      <= 16'h0000;
      arg_q      <= 3'd0;
      info_q     <= 2'd0;
      vcom_q     <= PowerOnVcomReset;
      vdir_one_q <= 1'b0;
      ppw_q      <= PixelsPerWordReset;
      rd_act_q   <= 1'b0;
      rd_pos_q   <= 3'd0;
      rd_val_q   <= 16'h0000;
      pix_q      <= '0;
      refr_q     <= 32'd0;
      wave_q     <= 16'h0000;
    end else begin
      phase_q    <= phase_d;
      hbh_q      <= hbh_d;
      hhb_q      <= hhb_d;
      cmd_q      <= cmd_d;
      arg_q      <= arg_d;
      info_q     <= info_d;
      vcom_q     <= vcom_d;
      vdir_one_q <= vdir_one_d;
      ppw_q      <= ppw_d;
      rd_act_q   <= rd_act_d;
      rd_pos_q   <= rd_pos_d;
      rd_val_q   <= rd_val_d;
      pix_q      <= pix_d;
      refr_q     <= refr_d;
      wave_q     <= wave_d;
    end
  end

  always_comb begin
    result_o.miso_byte       = miso;
    result_o.ready_level     = cfg_i.enabled;
    result_o.pixels_loaded   = pix_d;
    result_o.refresh_count   = refr_d;
    result_o.last_waveform   = wave_d;
    result_o.vcom_millivolts = vcom_d;
  end

  // A framing reset leaves the block at preamble with no burst open.
  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && action_i |=> phase_q == PhasePre && !rd_act_q && !hbh_q)
    else $error("framing reset left protocol state behind");

  // A disabled exchange returns zero and changes nothing.
  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !action_i && !cfg_i.enabled |-> miso == 8'h00 && hbh_d == hbh_q
    && phase_d == phase_q && rd_pos_d == rd_pos_q)
    else $error("disabled exchange touched state");

  // Burst position stays within the four bytes and is zero when idle.
  a_burst_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_pos_q[2] && (rd_act_q || rd_pos_q == 3'd0))
    else $error("read burst position out of range");

  // Byte pairing is suspended while a burst is open.
  a_no_pair_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_act_q |-> !hbh_q)
    else $error("high byte held during read burst");

  // Saturating counters never wrap down.
  a_totals_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_d >= pix_q && refr_d >= refr_q)
    else $error("pixel or refresh total decreased");

endmodule : spi_ep_core
`default_nettype wire

@@ design/spi_epaper_controller_model_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spi_epaper_controller_model_top: SPI slave model of an e-paper controller
// Pairs exchanged bytes into words, decodes preambles and commands, counts
// pixels and refreshes, handles VCOM and answers four-byte read bursts.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, action_i,         | host -> block
//          | mosi_byte_i                              |
//  out     | out_valid_o/out_ready_i, miso_byte_o,    | block -> host
//          | ready_level_o, pixels_loaded_o, ...      |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i,    | host -> block
//          | cfg_data_i                               |
//
// Each item passes from the input register through the protocol logic into
// the result register. One item is accepted every cycle while the result
// register is not stalled; the protocol state update, done once per item,
// sets that rate.
// Reset clears all protocol state, zeroes the totals, sets VCOM to 1530 mV
// and the configuration to its defaults; no clearing pass is needed.
// A result stalled in the output register holds the item in the input
// register; the input side takes one more item while the input register is
// empty, then stalls until the result is transferred.
// ----------------------------------------------------------------------------
module spi_epaper_controller_model_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // input items
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   action_i,
  input  wire logic [7:0]                             mosi_byte_i,
  // result items
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [7:0]                                  miso_byte_o,
  output logic                                        ready_level_o,
  output logic [spi_ep_pkg::PixelCountWidth-1:0]      pixels_loaded_o,
  output logic [31:0]                                 refresh_count_o,
  output logic [15:0]                                 last_waveform_o,
  output logic [15:0]                                 vcom_millivolts_o,
  // configuration writes
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [7:0]                             cfg_index_i,
  input  wire logic [15:0]                            cfg_data_i
);
  import spi_ep_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_q;

  logic       in_valid_q;
  logic       in_action_q;
  logic [7:0] in_mosi_q;
  logic       out_valid_q;
  logic       advance;
  logic       process;
  logic       in_xfer;

  // Advance whenever the result register is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || process;
  assign in_xfer    = in_valid_i && in_ready_o;

  spi_ep_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spi_ep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (process),
    .action_i    (in_action_q),
    .mosi_byte_i (in_mosi_q),
    .cfg_i       (cfg),
    .result_o    (res)
  );

  // Input register: hold the item until the core takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_action_q <= action_i;
      in_mosi_q   <= mosi_byte_i;
    end
  end

  // Result register: load on process, drop on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign miso_byte_o       = res_q.miso_byte;
  assign ready_level_o     = res_q.ready_level;
  assign pixels_loaded_o   = res_q.pixels_loaded;
  assign refresh_count_o   = res_q.refresh_count;
  assign last_waveform_o   = res_q.last_waveform;
  assign vcom_millivolts_o = res_q.vcom_millivolts;

  // A held item is taken by the core as soon as the result side frees up.
  a_no_lost_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("processed item produced no result");

  // A stalled result keeps its payload until transferred.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

  // No item is processed while the result register is blocked.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !process)
    else $error("result overwritten before transfer");

endmodule : spi_epaper_controller_model_top
`default_nettype wire
